@@ src/swa_pkg.sv @@
// Shared constants for the sliding window average block.
// No dependencies; imported by the top level.
package swa_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned WINDOW_DEF = 16;

endpackage

@@ src/swa_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module swa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/sliding_window_average_top.sv @@
// Moving average over the last WINDOW unsigned samples, one result per item.
// Depends on swa_pkg and swa_ram.
//
// The oldest sample is read from the ring RAM at acceptance; the update state then
// writes the new sample into the ring and updates the running sum with it. The
// restoring divider then takes one cycle per quotient bit, and the output state
// loads the output register once it is free. A new item is accepted only when the
// previous one has reached the output register, which may still be waiting to be
// taken. While fewer than WINDOW samples have arrived, the result is the sum divided
// by the number of samples so far; after that it is the sum divided by WINDOW, and
// window_full is set. The ring RAM needs no clearing after reset.
module sliding_window_average_top #(
  parameter int unsigned WINDOW = swa_pkg::WINDOW_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [swa_pkg::SAMPLE_W-1:0] in_sample,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [swa_pkg::SAMPLE_W-1:0] out_average,
  output logic                        out_window_full
);

  import swa_pkg::*;

  localparam int unsigned ADDR_W = $clog2(WINDOW);
  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W  = SAMPLE_W + $clog2(WINDOW);
  localparam int unsigned STEP_W = $clog2(SUM_W);
  localparam logic [CNT_W-1:0]  WIN_CNT   = CNT_W'(WINDOW);
  localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(WINDOW - 1);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_DIV,
    S_OUT
  } state_t;

  state_t               state_r, state_nxt;
  logic [SAMPLE_W-1:0]  sample_r, sample_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]    ptr_r, ptr_nxt;
  logic [SUM_W-1:0]     quo_r, quo_nxt;
  logic [CNT_W-1:0]     rem_r, rem_nxt;
  logic [CNT_W-1:0]     div_r, div_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;
  logic                 full_r, full_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0]  out_average_r, out_average_nxt;
  logic                 out_full_r, out_full_nxt;

  logic                 accept;
  logic                 ram_we;
  logic [SAMPLE_W-1:0]  ram_rdata;
  logic [SAMPLE_W-1:0]  oldest;
  logic [CNT_W-1:0]     cnt_inc;
  logic [CNT_W:0]       trial;
  logic                 trial_ge;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign ram_we   = (state_r == S_UPDATE);

  swa_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(WINDOW)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ptr_r),
    .wdata(sample_r),
    .re   (accept),
    .raddr(ptr_r),
    .rdata(ram_rdata)
  );

  assign oldest   = (cnt_r == WIN_CNT) ? ram_rdata : '0;
  assign cnt_inc  = (cnt_r == WIN_CNT) ? cnt_r : cnt_r + CNT_W'(1);
  assign trial    = {rem_r, quo_r[SUM_W-1]};
  assign trial_ge = (trial >= {1'b0, div_r});

  always_comb begin
    state_nxt       = state_r;
    sample_nxt      = sample_r;
    sum_nxt         = sum_r;
    cnt_nxt         = cnt_r;
    ptr_nxt         = ptr_r;
    quo_nxt         = quo_r;
    rem_nxt         = rem_r;
    div_nxt         = div_r;
    step_nxt        = step_r;
    full_nxt        = full_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_average_nxt = out_average_r;
    out_full_nxt    = out_full_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          sample_nxt = in_sample;
          state_nxt  = S_UPDATE;
        end
      end
      S_UPDATE: begin
        sum_nxt   = sum_r - SUM_W'(oldest) + SUM_W'(sample_r);
        quo_nxt   = sum_r - SUM_W'(oldest) + SUM_W'(sample_r);
        rem_nxt   = '0;
        div_nxt   = cnt_inc;
        cnt_nxt   = cnt_inc;
        full_nxt  = (cnt_inc == WIN_CNT);
        ptr_nxt   = (ptr_r == LAST_SLOT) ? '0 : ptr_r + ADDR_W'(1);
        step_nxt  = LAST_STEP;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (trial_ge) begin
          rem_nxt = CNT_W'(trial - {1'b0, div_r});
        end else begin
          rem_nxt = trial[CNT_W-1:0];
        end
        quo_nxt  = {quo_r[SUM_W-2:0], trial_ge};
        step_nxt = step_r - STEP_W'(1);
        if (step_r == '0) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_average_nxt = quo_r[SAMPLE_W-1:0];
          out_full_nxt    = full_r;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sum_r       <= '0;
      cnt_r       <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sample_r      <= sample_nxt;
    quo_r         <= quo_nxt;
    rem_r         <= rem_nxt;
    div_r         <= div_nxt;
    step_r        <= step_nxt;
    full_r        <= full_nxt;
    out_average_r <= out_average_nxt;
    out_full_r    <= out_full_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_average     = out_average_r;
  assign out_window_full = out_full_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("input accepted again before the previous item finished");

  a_full_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == WIN_CNT) |=> (cnt_r == WIN_CNT))
    else $error("fill count left the full window");

  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPDATE) |=> (state_r == S_DIV) && (step_r == LAST_STEP) && (rem_r == '0))
    else $error("divider not started correctly");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < div_r) && (div_r != '0))
    else $error("divider remainder out of range");

endmodule
